/* hw/rtl/hdma_pkg.sv */
// Shared types, constants and lookup functions for the DMA/HDMA channel controller.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package hdma_pkg;

    localparam int NUM_CH = 8;

    // Input opcodes.
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_DMA    = 3'd2;
    localparam logic [2:0] OP_HDMA   = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;
    localparam logic [2:0] OP_LINE   = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;
    localparam logic [2:0] OP_RETURN = 3'd7;

    // Result kinds.
    localparam logic [2:0] K_REG  = 3'd0;
    localparam logic [2:0] K_ARD  = 3'd1;
    localparam logic [2:0] K_BRD  = 3'd2;
    localparam logic [2:0] K_AWR  = 3'd3;
    localparam logic [2:0] K_BWR  = 3'd4;
    localparam logic [2:0] K_STAT = 3'd5;

    // Channel flag bits.
    localparam int F_FIXED = 0;
    localparam int F_DEC   = 1;
    localparam int F_IND   = 3;
    localparam int F_FROMB = 4;

    // Channel status bits.
    localparam int S_DMA  = 0;
    localparam int S_HDMA = 1;
    localparam int S_XFER = 2;
    localparam int S_TERM = 3;

    // Sequencer phase.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INIT = 2'd1;
    localparam logic [1:0] PH_LINE = 2'd2;
    localparam logic [1:0] PH_DMA  = 2'd3;

    // Position within one channel of a line walk.
    localparam logic [1:0] AT_CHAN  = 2'd0;
    localparam logic [1:0] AT_BYTE  = 2'd1;
    localparam logic [1:0] AT_AFTER = 2'd2;

    // What the pending read will fill.
    localparam logic [2:0] W_NONE = 3'd0;
    localparam logic [2:0] W_DATA = 3'd1;
    localparam logic [2:0] W_REP  = 3'd2;
    localparam logic [2:0] W_SLO  = 3'd3;
    localparam logic [2:0] W_SHI  = 3'd4;

    // Register indexes within a channel.
    localparam logic [3:0] R_MODE  = 4'h0;
    localparam logic [3:0] R_BADDR = 4'h1;
    localparam logic [3:0] R_ALO   = 4'h2;
    localparam logic [3:0] R_AHI   = 4'h3;
    localparam logic [3:0] R_ABANK = 4'h4;
    localparam logic [3:0] R_SLO   = 4'h5;
    localparam logic [3:0] R_SHI   = 4'h6;
    localparam logic [3:0] R_IBANK = 4'h7;
    localparam logic [3:0] R_TLO   = 4'h8;
    localparam logic [3:0] R_THI   = 4'h9;
    localparam logic [3:0] R_REP   = 4'ha;
    localparam logic [3:0] R_SPARE = 4'hb;
    localparam logic [3:0] R_SPAR2 = 4'hf;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_data;
        logic [7:0] open_bus;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] a_address;
        logic [7:0]  b_address;
        logic [7:0]  data;
        logic        busy_res;
        logic        last;
    } result_t;

    typedef struct packed {
        logic start;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic       walk_run;
        logic [1:0] res_n;
    } dp_status_t;

    // B-bus offset of byte idx in transfer mode m.
    function automatic logic [7:0] b_offset(input logic [2:0] m, input logic [1:0] idx);
        logic [7:0] r;
        begin
            r = 8'd0;
            case (m)
                3'd1, 3'd5: r = {7'd0, idx[0]};
                3'd3, 3'd7: r = {7'd0, idx[1]};
                3'd4:       r = {6'd0, idx};
                default:    r = 8'd0;
            endcase
            return r;
        end
    endfunction

    // Bytes per HDMA unit in transfer mode m.
    function automatic logic [2:0] xfer_len(input logic [2:0] m);
        logic [2:0] r;
        begin
            case (m)
                3'd0:             r = 3'd1;
                3'd1, 3'd2, 3'd6: r = 3'd2;
                default:          r = 3'd4;
            endcase
            return r;
        end
    endfunction

    function automatic result_t make_res(input logic [2:0] kind, input logic [23:0] a,
                                         input logic [7:0] b, input logic [7:0] d,
                                         input logic busy);
        result_t r;
        begin
            r.kind      = kind;
            r.a_address = a;
            r.b_address = b;
            r.data      = d;
            r.busy_res  = busy;
            r.last      = 1'b0;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/hdma_dp.sv */
// Datapath: channel register file, sequencer state, HDMA debt and result buffer.
// Depends on hdma_pkg; driven by commands from hdma_ctrl.
`default_nettype none
module hdma_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hdma_pkg::dp_cmd_t   cmd,
    input  wire hdma_pkg::item_t     item,
    input  wire logic                res_idx,
    output hdma_pkg::dp_status_t     status,
    output hdma_pkg::result_t        res
);
    import hdma_pkg::*;

    localparam logic [3:0] NCH4 = 4'(NUM_CH);

    logic [2:0]  mode_reg   [NUM_CH], mode_next   [NUM_CH];
    logic [4:0]  flags_reg  [NUM_CH], flags_next  [NUM_CH];
    logic [7:0]  baddr_reg  [NUM_CH], baddr_next  [NUM_CH];
    logic [15:0] aaddr_reg  [NUM_CH], aaddr_next  [NUM_CH];
    logic [7:0]  abank_reg  [NUM_CH], abank_next  [NUM_CH];
    logic [15:0] size_reg   [NUM_CH], size_next   [NUM_CH];
    logic [7:0]  ibank_reg  [NUM_CH], ibank_next  [NUM_CH];
    logic [15:0] taddr_reg  [NUM_CH], taddr_next  [NUM_CH];
    logic [7:0]  rep_reg    [NUM_CH], rep_next    [NUM_CH];
    logic [7:0]  spare_reg  [NUM_CH], spare_next  [NUM_CH];
    logic [3:0]  stat_reg   [NUM_CH], stat_next   [NUM_CH];
    logic [1:0]  off_reg    [NUM_CH], off_next    [NUM_CH];

    logic [9:0]  debt_reg, debt_next;
    logic        busy_reg, busy_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  chan_reg, chan_next;
    logic [1:0]  at_reg, at_next;
    logic [2:0]  byte_reg, byte_next;
    logic [2:0]  wait_reg, wait_next;
    logic        hit_reg, hit_next;
    logic [2:0]  wkind_reg, wkind_next;
    logic [23:0] wa_reg, wa_next;
    logic [7:0]  wb_reg, wb_next;
    logic        run_reg, run_next;
    logic [1:0]  rn_reg, rn_next;
    result_t     rbuf_reg [2], rbuf_next [2];

    always_comb begin
        logic [2:0]  c;
        logic [2:0]  ch;
        logic [2:0]  m;
        logic [1:0]  off;
        logic [7:0]  b;
        logic [23:0] a;
        logic [15:0] sz;
        logic        found;
        logic [3:0]  ci;
        logic [7:0]  rv;
        logic        fin;

        mode_next  = mode_reg;  flags_next = flags_reg; baddr_next = baddr_reg;
        aaddr_next = aaddr_reg; abank_next = abank_reg; size_next  = size_reg;
        ibank_next = ibank_reg; taddr_next = taddr_reg; rep_next   = rep_reg;
        spare_next = spare_reg; stat_next  = stat_reg;  off_next   = off_reg;
        debt_next  = debt_reg;  busy_next  = busy_reg;  phase_next = phase_reg;
        chan_next  = chan_reg;  at_next    = at_reg;    byte_next  = byte_reg;
        wait_next  = wait_reg;  hit_next   = hit_reg;   wkind_next = wkind_reg;
        wa_next    = wa_reg;    wb_next    = wb_reg;    run_next   = run_reg;
        rn_next    = rn_reg;    rbuf_next  = rbuf_reg;
        c = item.reg_addr[6:4];
        ch = chan_reg[2:0];
        m = 3'd0; off = 2'd0; b = 8'd0; a = 24'd0; sz = 16'd0;
        found = 1'b0; ci = 4'd0; rv = 8'd0; fin = 1'b0;

        if (cmd.start) begin
            rn_next = 2'd0;
            run_next = 1'b0;
            if (item.opcode != OP_RETURN && phase_reg != PH_IDLE) begin
                phase_next = PH_IDLE;
                wait_next  = W_NONE;
            end
            case (item.opcode)
                OP_WRITE: begin
                    if (32'(c) < NUM_CH) begin
                        unique case (item.reg_addr[3:0])
                            R_MODE: begin
                                mode_next[c]  = item.write_data[2:0];
                                flags_next[c] = item.write_data[7:3];
                            end
                            R_BADDR: baddr_next[c] = item.write_data;
                            R_ALO:   aaddr_next[c][7:0] = item.write_data;
                            R_AHI:   aaddr_next[c][15:8] = item.write_data;
                            R_ABANK: abank_next[c] = item.write_data;
                            R_SLO:   size_next[c][7:0] = item.write_data;
                            R_SHI:   size_next[c][15:8] = item.write_data;
                            R_IBANK: ibank_next[c] = item.write_data;
                            R_TLO:   taddr_next[c][7:0] = item.write_data;
                            R_THI:   taddr_next[c][15:8] = item.write_data;
                            R_REP:   rep_next[c] = item.write_data;
                            R_SPARE, R_SPAR2: spare_next[c] = item.write_data;
                            default: ;
                        endcase
                    end
                end
                OP_READ: begin
                    rv = item.open_bus;
                    if (32'(c) < NUM_CH) begin
                        unique case (item.reg_addr[3:0])
                            R_MODE:  rv = {flags_reg[c], mode_reg[c]};
                            R_BADDR: rv = baddr_reg[c];
                            R_ALO:   rv = aaddr_reg[c][7:0];
                            R_AHI:   rv = aaddr_reg[c][15:8];
                            R_ABANK: rv = abank_reg[c];
                            R_SLO:   rv = size_reg[c][7:0];
                            R_SHI:   rv = size_reg[c][15:8];
                            R_IBANK: rv = ibank_reg[c];
                            R_TLO:   rv = taddr_reg[c][7:0];
                            R_THI:   rv = taddr_reg[c][15:8];
                            R_REP:   rv = rep_reg[c];
                            R_SPARE, R_SPAR2: rv = spare_reg[c];
                            default: rv = item.open_bus;
                        endcase
                    end
                    rbuf_next[0] = make_res(K_REG, 24'd0, 8'd0, rv, 1'b0);
                    rn_next = 2'd1;
                end
                OP_DMA, OP_HDMA: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (item.opcode == OP_DMA) stat_next[i][S_DMA] = item.write_data[i];
                        else stat_next[i][S_HDMA] = item.write_data[i];
                    end
                    if (item.opcode == OP_DMA) busy_next = (item.write_data != 8'd0);
                end
                OP_INIT, OP_LINE: begin
                    debt_next  = 10'd0;
                    phase_next = (item.opcode == OP_INIT) ? PH_INIT : PH_LINE;
                    chan_next  = 4'd0;
                    at_next    = AT_CHAN;
                    byte_next  = 3'd0;
                    hit_next   = 1'b0;
                    wait_next  = W_NONE;
                    run_next   = 1'b1;
                end
                OP_TICK: begin
                    if (debt_reg != 10'd0) begin
                        debt_next = (debt_reg >= 10'd2) ? debt_reg - 10'd2 : 10'd0;
                        rbuf_next[0] = make_res(K_STAT, 24'd0, 8'd0, 8'd0, 1'b1);
                        rn_next = 2'd1;
                    end else if (busy_reg) begin
                        rbuf_next[0] = make_res(K_STAT, 24'd0, 8'd0, 8'd0, 1'b1);
                        rn_next = 2'd1;
                        // Lowest channel with DMA active wins.
                        for (int i = NUM_CH - 1; i >= 0; i--) begin
                            if (stat_reg[i][S_DMA]) begin
                                found = 1'b1;
                                ci = 4'(i);
                            end
                        end
                        if (!found) begin
                            busy_next = 1'b0;
                        end else begin
                            m   = mode_reg[ci[2:0]];
                            off = off_reg[ci[2:0]];
                            b   = baddr_reg[ci[2:0]] + b_offset(m, off);
                            a   = {abank_reg[ci[2:0]], aaddr_reg[ci[2:0]]};
                            phase_next = PH_DMA;
                            wait_next  = W_DATA;
                            if (flags_reg[ci[2:0]][F_FROMB]) begin
                                rbuf_next[1] = make_res(K_BRD, 24'd0, b, 8'd0, 1'b0);
                                wkind_next = K_AWR; wa_next = a; wb_next = 8'd0;
                            end else begin
                                rbuf_next[1] = make_res(K_ARD, a, 8'd0, 8'd0, 1'b0);
                                wkind_next = K_BWR; wa_next = 24'd0; wb_next = b;
                            end
                            rn_next = 2'd2;
                            off_next[ci[2:0]] = off + 2'd1;
                            if (!flags_reg[ci[2:0]][F_FIXED]) begin
                                aaddr_next[ci[2:0]] = flags_reg[ci[2:0]][F_DEC]
                                    ? aaddr_reg[ci[2:0]] - 16'd1
                                    : aaddr_reg[ci[2:0]] + 16'd1;
                            end
                            sz = size_reg[ci[2:0]] - 16'd1;
                            size_next[ci[2:0]] = sz;
                            if (sz == 16'd0) begin
                                off_next[ci[2:0]] = 2'd0;
                                stat_next[ci[2:0]][S_DMA] = 1'b0;
                            end
                        end
                    end else begin
                        rbuf_next[0] = make_res(K_STAT, 24'd0, 8'd0, 8'd0, 1'b0);
                        rn_next = 2'd1;
                    end
                end
                default: begin
                    if (phase_reg != PH_IDLE && wait_reg != W_NONE) begin
                        rv = rep_reg[ch];
                        case (wait_reg)
                            W_DATA: begin
                                rbuf_next[0] = make_res(wkind_reg, wa_reg, wb_reg,
                                                        item.read_data, 1'b0);
                                rn_next = 2'd1;
                                wait_next = W_NONE;
                                if (phase_reg == PH_LINE) begin
                                    byte_next = byte_reg + 3'd1;
                                    run_next = 1'b1;
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            W_REP: begin
                                rep_next[ch] = item.read_data;
                                rv = item.read_data;
                                if (flags_reg[ch][F_IND]) begin
                                    rbuf_next[0] = make_res(K_ARD,
                                        {abank_reg[ch], taddr_reg[ch]}, 8'd0, 8'd0, 1'b0);
                                    rn_next = 2'd1;
                                    taddr_next[ch] = taddr_reg[ch] + 16'd1;
                                    wait_next = W_SLO;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            W_SLO: begin
                                size_next[ch] = {8'd0, item.read_data};
                                rbuf_next[0] = make_res(K_ARD,
                                    {abank_reg[ch], taddr_reg[ch]}, 8'd0, 8'd0, 1'b0);
                                rn_next = 2'd1;
                                taddr_next[ch] = taddr_reg[ch] + 16'd1;
                                wait_next = W_SHI;
                            end
                            W_SHI: begin
                                size_next[ch] = size_reg[ch] | {item.read_data, 8'd0};
                                if (phase_reg == PH_LINE) debt_next = debt_reg + 10'd16;
                                fin = 1'b1;
                            end
                            default: ;
                        endcase
                        if (fin) begin
                            if (phase_reg == PH_INIT) stat_next[ch][S_TERM] = 1'b0;
                            else if (rv == 8'd0) stat_next[ch][S_TERM] = 1'b1;
                            stat_next[ch][S_XFER] = 1'b1;
                            wait_next = W_NONE;
                            chan_next = chan_reg + 4'd1;
                            at_next   = AT_CHAN;
                            run_next  = 1'b1;
                        end
                    end
                end
            endcase
        end else if (cmd.step) begin
            // One pass of the channel walk per cycle, until the walk halts to wait for read data.
            m = mode_reg[ch];
            if (chan_reg >= NCH4) begin
                if (hit_reg) debt_next = debt_reg + 10'd16;
                phase_next = PH_IDLE;
                wait_next  = W_NONE;
                run_next   = 1'b0;
            end else if (phase_reg == PH_INIT) begin
                if (stat_reg[ch][S_HDMA]) begin
                    hit_next = 1'b1;
                    stat_next[ch][S_DMA] = 1'b0;
                    off_next[ch] = 2'd0;
                    debt_next = debt_reg + (flags_reg[ch][F_IND] ? 10'd24 : 10'd8);
                    if (rn_reg < 2'd2) begin
                        rbuf_next[rn_reg[0]] = make_res(K_ARD,
                            {abank_reg[ch], aaddr_reg[ch]}, 8'd0, 8'd0, 1'b0);
                        rn_next = rn_reg + 2'd1;
                    end
                    taddr_next[ch] = aaddr_reg[ch] + 16'd1;
                    wait_next = W_REP;
                    run_next  = 1'b0;
                end else begin
                    stat_next[ch][S_XFER] = 1'b0;
                    stat_next[ch][S_TERM] = 1'b0;
                    chan_next = chan_reg + 4'd1;
                    at_next   = AT_CHAN;
                end
            end else if (at_reg == AT_CHAN) begin
                if (stat_reg[ch][S_HDMA] && !stat_reg[ch][S_TERM]) begin
                    hit_next = 1'b1;
                    stat_next[ch][S_DMA] = 1'b0;
                    off_next[ch] = 2'd0;
                    debt_next = debt_reg + 10'd8;
                    byte_next = 3'd0;
                    at_next = stat_reg[ch][S_XFER] ? AT_BYTE : AT_AFTER;
                end else begin
                    chan_next = chan_reg + 4'd1;
                    at_next   = AT_CHAN;
                end
            end else if (at_reg == AT_BYTE) begin
                if (byte_reg < xfer_len(m)) begin
                    b = baddr_reg[ch] + b_offset(m, byte_reg[1:0]);
                    debt_next = debt_reg + 10'd8;
                    if (flags_reg[ch][F_IND]) begin
                        a = {ibank_reg[ch], size_reg[ch]};
                        size_next[ch] = size_reg[ch] + 16'd1;
                    end else begin
                        a = {abank_reg[ch], taddr_reg[ch]};
                        taddr_next[ch] = taddr_reg[ch] + 16'd1;
                    end
                    if (rn_reg < 2'd2) begin
                        if (flags_reg[ch][F_FROMB])
                            rbuf_next[rn_reg[0]] = make_res(K_BRD, 24'd0, b, 8'd0, 1'b0);
                        else
                            rbuf_next[rn_reg[0]] = make_res(K_ARD, a, 8'd0, 8'd0, 1'b0);
                        rn_next = rn_reg + 2'd1;
                    end
                    if (flags_reg[ch][F_FROMB]) begin
                        wkind_next = K_AWR; wa_next = a; wb_next = 8'd0;
                    end else begin
                        wkind_next = K_BWR; wa_next = 24'd0; wb_next = b;
                    end
                    wait_next = W_DATA;
                    run_next  = 1'b0;
                end else begin
                    at_next = AT_AFTER;
                end
            end else begin
                rv = rep_reg[ch] - 8'd1;
                rep_next[ch] = rv;
                stat_next[ch][S_XFER] = rv[7];
                if (rv[6:0] == 7'd0) begin
                    if (rn_reg < 2'd2) begin
                        rbuf_next[rn_reg[0]] = make_res(K_ARD,
                            {abank_reg[ch], taddr_reg[ch]}, 8'd0, 8'd0, 1'b0);
                        rn_next = rn_reg + 2'd1;
                    end
                    taddr_next[ch] = taddr_reg[ch] + 16'd1;
                    wait_next = W_REP;
                    run_next  = 1'b0;
                end else begin
                    chan_next = chan_reg + 4'd1;
                    at_next   = AT_CHAN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                mode_reg[i]  <= 3'd7;
                flags_reg[i] <= 5'h1f;
                baddr_reg[i] <= 8'hff;
                aaddr_reg[i] <= 16'hffff;
                abank_reg[i] <= 8'hff;
                size_reg[i]  <= 16'hffff;
                ibank_reg[i] <= 8'hff;
                taddr_reg[i] <= 16'hffff;
                rep_reg[i]   <= 8'hff;
                spare_reg[i] <= 8'hff;
                stat_reg[i]  <= 4'd0;
                off_reg[i]   <= 2'd0;
            end
            debt_reg  <= 10'd0;
            busy_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            chan_reg  <= 4'd0;
            at_reg    <= AT_CHAN;
            byte_reg  <= 3'd0;
            wait_reg  <= W_NONE;
            hit_reg   <= 1'b0;
            wkind_reg <= K_REG;
            wa_reg    <= 24'd0;
            wb_reg    <= 8'd0;
            run_reg   <= 1'b0;
            rn_reg    <= 2'd0;
        end else begin
            mode_reg  <= mode_next;  flags_reg <= flags_next; baddr_reg <= baddr_next;
            aaddr_reg <= aaddr_next; abank_reg <= abank_next; size_reg  <= size_next;
            ibank_reg <= ibank_next; taddr_reg <= taddr_next; rep_reg   <= rep_next;
            spare_reg <= spare_next; stat_reg  <= stat_next;  off_reg   <= off_next;
            debt_reg  <= debt_next;  busy_reg  <= busy_next;  phase_reg <= phase_next;
            chan_reg  <= chan_next;  at_reg    <= at_next;    byte_reg  <= byte_next;
            wait_reg  <= wait_next;  hit_reg   <= hit_next;   wkind_reg <= wkind_next;
            wa_reg    <= wa_next;    wb_reg    <= wb_next;    run_reg   <= run_next;
            rn_reg    <= rn_next;
        end
    end

    always_ff @(posedge clk) begin
        rbuf_reg <= rbuf_next;
    end

    always_comb begin
        res = rbuf_reg[res_idx];
        res.last = ({1'b0, res_idx} == rn_reg - 2'd1);
    end

    assign status.walk_run = run_reg;
    assign status.res_n    = rn_reg;

endmodule
`default_nettype wire

/* hw/rtl/hdma_ctrl.sv */
// Controller state machine: takes one transaction, runs the channel walk, drains results.
// Depends on hdma_pkg; commands hdma_dp.
`default_nettype none
module hdma_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    input  wire hdma_pkg::dp_status_t  status,
    output hdma_pkg::dp_cmd_t          dp_cmd,
    output logic                       res_idx
);
    import hdma_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       idx_reg, idx_next;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        dp_cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    dp_cmd.start = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.walk_run) begin
                    dp_cmd.step = 1'b1;
                end else if (status.res_n != 2'd0) begin
                    idx_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!res_stall) begin
                    if ({1'b0, idx_reg} == status.res_n - 2'd1) state_next = ST_IDLE;
                    else idx_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res_idx   = idx_reg;

endmodule
`default_nettype wire

/* hw/rtl/dma_hdma_channel_controller.sv */
// Top level: eight-channel DMA/HDMA controller, controller plus datapath.
// Depends on hdma_pkg, hdma_ctrl and hdma_dp.
// One transaction at a time: it is accepted and executed, plus one step per cycle of a
// frame-init or line walk, then one result per cycle unless the output stalls.
// Reset is asynchronous, active low, and restores every channel register at once.
`default_nettype none
module dma_hdma_channel_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire hdma_pkg::item_t    cmd,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output hdma_pkg::result_t       res
);
    import hdma_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       res_idx;

    hdma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (dp_status),
        .dp_cmd    (dp_cmd),
        .res_idx   (res_idx)
    );

    hdma_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .item    (cmd),
        .res_idx (res_idx),
        .status  (dp_status),
        .res     (res)
    );

endmodule
`default_nettype wire

/* hw/rtl/hdma_checker.sv */
// Port-level checks on the DMA/HDMA controller, bound to the top level.
// Depends on hdma_pkg for the transaction types.
`default_nettype none
module hdma_port_checks (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_stall,
    input wire hdma_pkg::item_t   cmd,
    input wire logic              res_valid,
    input wire logic              res_stall,
    input wire hdma_pkg::result_t res
);
    import hdma_pkg::*;

    // Results are only shown while the input side is held off.
    a_res_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall) else $error("result shown while input open");

    // No result is shown in the cycle after a transaction is accepted.
    a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> !res_valid) else $error("result too early");

    // After the final result of a transaction the output goes quiet.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res.last) |=> !res_valid)
        else $error("result after last");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind dma_hdma_channel_controller hdma_port_checks u_hdma_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
`default_nettype wire
